// ----- rtl/ttw_pkg.sv -----
// Shared constants, character codes and types for the text terminal writer.
package ttw_pkg;

    localparam int IDX_W       = 11;
    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int TAB_STOP    = 8;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0720;
    localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h07;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic              wr_back;
        logic              row_adv;
        logic [CHAR_W-1:0] wr_char;
    } t_put_ctl;

endpackage

// ----- rtl/ttw_cursor.sv -----
// Cursor update and cell write decision for one put character.
module ttw_cursor
    import ttw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS
) (
    input  logic [CHAR_W-1:0]          i_char_code,
    input  logic [$clog2(COLUMNS)-1:0] i_col,
    output logic [$clog2(COLUMNS)-1:0] o_col,
    output t_put_ctl                   o_ctl
);

    localparam int CW = $clog2(COLUMNS);
    localparam logic [CW:0] COLS_X = (CW+1)'(COLUMNS);
    localparam logic [CW:0] STEP_X = (CW+1)'(TAB_STOP);
    localparam logic [CW:0] MASK_X = ~((CW+1)'(TAB_STOP - 1));

    logic [CW:0] tab_col;
    logic [CW:0] inc_col;

    assign tab_col = ({1'b0, i_col} + STEP_X) & MASK_X;
    assign inc_col = {1'b0, i_col} + (CW+1)'(1);

    always_comb begin
        o_col         = i_col;
        o_ctl.wr_en   = 1'b0;
        o_ctl.wr_back = 1'b0;
        o_ctl.row_adv = 1'b0;
        o_ctl.wr_char = i_char_code;
        unique case (i_char_code)
            CH_CR: begin
                o_col = '0;
            end
            CH_LF: begin
                o_col         = '0;
                o_ctl.row_adv = 1'b1;
            end
            CH_TAB: begin
                if (tab_col >= COLS_X) begin
                    o_col         = CW'(tab_col - COLS_X);
                    o_ctl.row_adv = 1'b1;
                end else begin
                    o_col = CW'(tab_col);
                end
            end
            CH_BS: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_char = CH_SPACE;
                if (i_col != '0) begin
                    o_col         = i_col - CW'(1);
                    o_ctl.wr_back = 1'b1;
                end
            end
            CH_NUL, CH_FF, CH_BEL: begin
                o_col = i_col;
            end
            default: begin
                o_ctl.wr_en = 1'b1;
                if (inc_col == COLS_X) begin
                    o_col         = '0;
                    o_ctl.row_adv = 1'b1;
                end else begin
                    o_col = CW'(inc_col);
                end
            end
        endcase
    end

endmodule

// ----- rtl/text_terminal_writer_core.sv -----
// Top level of the text terminal writer: screen memory, cursor and sequencer.
//
// Usage: pulse start while busy is low to hand over one beat (a put or a read).
// A put that does not scroll keeps busy low, and the result strobe o_done follows
// in the next cycle. A read goes through the registered read port of the screen
// memory and then the S_READ state, with busy high. A put that moves past the last
// row scrolls the screen through the memory's single write port: one cell per cycle
// for the copy and for the blank bottom row, with busy high. After reset a clearing
// pass writes every cell once, with busy high. Each result shows for exactly one
// cycle on o_done and is not held: the receiver must take it then. The color
// register takes writes at any time and is to be written only while the block is
// idle.
module text_terminal_writer_core
    import ttw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_read_index,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_cursor_index,
    output logic [CELL_W-1:0] o_cell_value,
    output logic              o_scrolled,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CHAR_W-1:0] i_cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;

    logic [CELL_W-1:0] mem [CELLS];

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_lin, n_lin;
    logic [CHAR_W-1:0] r_color;
    logic              r_rd_ok, n_rd_ok;
    logic              r_cp_pend, n_cp_pend;
    logic [AW-1:0]     r_cp_addr, n_cp_addr;
    logic [CELL_W-1:0] r_rd_data;
    logic              r_done, n_done;
    logic [IDX_W-1:0]  r_cidx, n_cidx;
    logic [CELL_W-1:0] r_cell, n_cell;
    logic              r_scr, n_scr;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic [CW-1:0]     put_col;
    t_put_ctl          put_ctl;
    logic              put_scroll;
    logic [RW-1:0]     put_row;
    logic [AW-1:0]     put_lin;

    ttw_cursor #(
        .COLUMNS (COLUMNS)
    ) u_cursor (
        .i_char_code (i_char_code),
        .i_col       (r_col),
        .o_col       (put_col),
        .o_ctl       (put_ctl)
    );

    assign put_scroll = put_ctl.row_adv && (r_row == LAST_ROW);
    assign put_row    = (put_ctl.row_adv && !put_scroll) ? r_row + RW'(1) : r_row;
    assign put_lin    = AW'(put_row) * COLS_A + AW'(put_col);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_row     = r_row;
        n_col     = r_col;
        n_lin     = r_lin;
        n_rd_ok   = r_rd_ok;
        n_cp_pend = 1'b0;
        n_cp_addr = r_ptr;
        n_done    = 1'b0;
        n_cidx    = r_cidx;
        n_cell    = '0;
        n_scr     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = BLANK_CELL;
        mem_re    = 1'b0;
        mem_raddr = r_ptr + COLS_A;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_READ) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(i_read_index);
                        n_rd_ok   = 32'(i_read_index) < CELLS;
                        n_state   = S_READ;
                    end else begin
                        if (put_ctl.wr_en) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_lin - AW'(put_ctl.wr_back);
                            mem_wdata = {r_color, put_ctl.wr_char};
                        end
                        n_col = put_col;
                        n_row = put_row;
                        n_lin = put_lin;
                        if (put_scroll) begin
                            n_ptr   = '0;
                            n_state = S_COPY;
                        end else begin
                            n_done = 1'b1;
                            n_cidx = IDX_W'(put_lin);
                        end
                    end
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_cidx  = IDX_W'(r_lin);
                n_cell  = r_rd_ok ? r_rd_data : '0;
                n_state = S_IDLE;
            end
            S_COPY: begin
                mem_re    = 1'b1;
                n_cp_pend = 1'b1;
                if (r_cp_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cp_addr;
                    mem_wdata = r_rd_data;
                end
                n_ptr = r_ptr + AW'(1);
                if (r_ptr == COPY_LAST) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_cp_pend) begin
                    mem_waddr = r_cp_addr;
                    mem_wdata = r_rd_data;
                end else begin
                    mem_wdata = {r_color, CH_SPACE};
                    if (r_ptr == LAST_CELL) begin
                        n_ptr   = '0;
                        n_done  = 1'b1;
                        n_scr   = 1'b1;
                        n_cidx  = IDX_W'(r_lin);
                        n_state = S_IDLE;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ptr     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_lin     <= '0;
            r_color   <= COLOR_RESET;
            r_cp_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_row     <= n_row;
            r_col     <= n_col;
            r_lin     <= n_lin;
            r_cp_pend <= n_cp_pend;
            r_done    <= n_done;
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok   <= n_rd_ok;
        r_cp_addr <= n_cp_addr;
        r_cidx    <= n_cidx;
        r_cell    <= n_cell;
        r_scr     <= n_scr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_done         = r_done;
    assign o_cursor_index = r_cidx;
    assign o_cell_value   = r_cell;
    assign o_scrolled     = r_scr;

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (r_row == LAST_ROW))
        else $error("scroll result with cursor off the last row");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("cursor column out of range");

    a_copy_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> (r_state == S_COPY || r_state == S_FILL))
        else $error("copy write pending outside scroll");

    a_no_done_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !o_done)
        else $error("result strobe during clearing pass");

    a_lin_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_lin == AW'(r_row) * COLS_A + AW'(r_col)))
        else $error("linear cursor index out of step with row and column");

endmodule
